// ===== design/fixed_point_q24_8_alu_unit_macros.svh =====
// Assertion macros for the fixed-point ALU back end (fxa_back.sv).
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FXA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fxa assertion failed");
`define FXA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fxa assertion failed");
`else
`define FXA_ASSERT_SAME(label, ante, cons)
`define FXA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/fxa_pkg.sv =====
// Types, constants and helper functions of the fixed-point ALU.
`default_nettype none
package fxa_pkg;
  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_W       = WORD_WIDTH + FRAC_BITS;
  localparam int DIV_STEPS   = NUM_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE, KIND_MUL, KIND_DIV
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // One classified word as it waits in the queue.
  typedef struct packed {
    kind_t                 kind;
    logic [WORD_WIDTH-1:0] res;
    logic                  cmp;
    logic [1:0]            st;
    logic                  neg;
    logic [WORD_WIDTH-1:0] ma;
    logic [WORD_WIDTH-1:0] mb;
  } item_t;

  // One stage of the back-end pipeline.
  typedef struct packed {
    logic                  vld;
    kind_t                 kind;
    logic [WORD_WIDTH-1:0] res;
    logic                  cmp;
    logic [1:0]            st;
    logic                  neg;
    logic [WORD_WIDTH-1:0] mb;
    logic [WORD_WIDTH-1:0] rem;
    logic [NUM_W-1:0]      nq;
  } stage_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] val;
    logic                  ovf;
  } sat_t;

  // Signed magnitude to a raw word, saturating at the range limits.
  function automatic sat_t sat_mag(input logic neg, input logic [63:0] mag);
    sat_t r;
    if (!neg) begin
      r.ovf = (mag > {{(64-WORD_WIDTH){1'b0}}, WORD_MAX});
      r.val = r.ovf ? WORD_MAX : mag[WORD_WIDTH-1:0];
    end else begin
      r.ovf = (mag > {{(64-WORD_WIDTH){1'b0}}, WORD_MIN});
      r.val = r.ovf ? WORD_MIN : (~mag[WORD_WIDTH-1:0] + 1'b1);
    end
    return r;
  endfunction

  // Saturate a sum that carries one guard bit.
  function automatic sat_t sat_sum(input logic [WORD_WIDTH:0] s);
    sat_t r;
    r.ovf = (s[WORD_WIDTH] != s[WORD_WIDTH-1]);
    r.val = r.ovf ? (s[WORD_WIDTH] ? WORD_MIN : WORD_MAX) : s[WORD_WIDTH-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== design/fxa_ifs.sv =====
// Channel interfaces for operand words and result words.
`default_nettype none
interface fxa_in_if import fxa_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic [3:0]                   op;
  logic signed [WORD_WIDTH-1:0] operand_a;
  logic signed [WORD_WIDTH-1:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if import fxa_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] result_value;
  logic                         compare_true;
  logic [1:0]                   status;
  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface
`default_nettype wire

// ===== design/fxa_front.sv =====
// Front end: accepts operand words, finishes the short ops and classifies the rest.
`default_nettype none
module fxa_front import fxa_pkg::*; (
  fxa_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output item_t  q_item
);
  logic [WORD_WIDTH-1:0] a, b;
  logic                  na, nb;
  logic signed [WORD_WIDTH-1:0] sa, sb;
  logic [WORD_WIDTH:0]   sum, dif, incv, decv;
  logic [FRAC_BITS:0]    top_bits;
  op_t                   op;
  sat_t                  s;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    a    = in_ch.operand_a;
    b    = in_ch.operand_b;
    sa   = in_ch.operand_a;
    sb   = in_ch.operand_b;
    na   = a[WORD_WIDTH-1];
    nb   = b[WORD_WIDTH-1];
    op   = op_t'(in_ch.op);
    sum  = {na, a} + {nb, b};
    dif  = {na, a} - {nb, b};
    incv = {na, a} + {{WORD_WIDTH{1'b0}}, 1'b1};
    decv = {na, a} - {{WORD_WIDTH{1'b0}}, 1'b1};
    top_bits = a[WORD_WIDTH-1 -: FRAC_BITS+1];
    s = '0;

    q_item      = '0;
    q_item.kind = KIND_DONE;
    q_item.st   = ST_OK;
    q_item.neg  = na ^ nb;
    q_item.ma   = na ? (~a + 1'b1) : a;
    q_item.mb   = nb ? (~b + 1'b1) : b;

    case (op)
      OP_ADD: begin s = sat_sum(sum); q_item.res = s.val; q_item.st = s.ovf ? ST_OVF : ST_OK; end
      OP_SUB: begin s = sat_sum(dif); q_item.res = s.val; q_item.st = s.ovf ? ST_OVF : ST_OK; end
      OP_INC: begin s = sat_sum(incv); q_item.res = s.val; q_item.st = s.ovf ? ST_OVF : ST_OK; end
      OP_DEC: begin s = sat_sum(decv); q_item.res = s.val; q_item.st = s.ovf ? ST_OVF : ST_OK; end
      OP_MUL: q_item.kind = KIND_MUL;
      OP_DIV: begin
        if (b == '0) begin
          q_item.st  = ST_DIVZ;
          q_item.res = na ? WORD_MIN : WORD_MAX;
        end else begin
          q_item.kind = KIND_DIV;
        end
      end
      OP_GT:  q_item.cmp = (sa > sb);
      OP_LT:  q_item.cmp = (sa < sb);
      OP_GE:  q_item.cmp = (sa >= sb);
      OP_LE:  q_item.cmp = (sa <= sb);
      OP_EQ:  q_item.cmp = (a == b);
      OP_NE:  q_item.cmp = (a != b);
      OP_MIN: q_item.res = (sa < sb) ? a : b;
      OP_MAX: q_item.res = (sa > sb) ? a : b;
      OP_TO_INT: q_item.res = WORD_WIDTH'(sa >>> FRAC_BITS);
      OP_FROM_INT: begin
        // The shift fits only when the bits shifted out and the new sign bit all match the sign.
        if ((&top_bits) || !(|top_bits)) begin
          q_item.res = a << FRAC_BITS;
        end else begin
          q_item.res = na ? WORD_MIN : WORD_MAX;
          q_item.st  = ST_OVF;
        end
      end
      default: q_item.kind = KIND_DONE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/fxa_queue.sv =====
// Short word queue between the front end and the back-end pipeline.
`default_nettype none
module fxa_queue import fxa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);
  item_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule
`default_nettype wire

// ===== design/fxa_back.sv =====
// Back end: multiplier, bit-per-stage divider pipeline and the result register.
`default_nettype none
`include "fixed_point_q24_8_alu_unit_macros.svh"
module fxa_back import fxa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  item_t    q_item,
  output logic     q_pop,
  fxa_out_if.source out_ch
);
  stage_t                  stg_r [DIV_STEPS+1];
  logic [2*WORD_WIDTH-1:0] prod_r;
  logic                    en;
  logic                    out_vld_r;
  logic [WORD_WIDTH-1:0]   out_res_r;
  logic                    out_cmp_r;
  logic [1:0]              out_st_r;

  // The whole pipeline moves only when the result register can take a word.
  assign en    = !out_vld_r || out_ch.ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].vld <= 1'b0;
    end else if (en) begin
      stg_r[0].vld <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].kind <= q_item.kind;
      stg_r[0].res  <= q_item.res;
      stg_r[0].cmp  <= q_item.cmp;
      stg_r[0].st   <= q_item.st;
      stg_r[0].neg  <= q_item.neg;
      stg_r[0].mb   <= q_item.mb;
      stg_r[0].rem  <= '0;
      stg_r[0].nq   <= {q_item.ma, {FRAC_BITS{1'b0}}};
      prod_r        <= q_item.ma * q_item.mb;
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
    stage_t              stg_nxt;
    logic [WORD_WIDTH:0] trial;
    logic [2*WORD_WIDTH:0] rounded;
    logic [63:0]         mul_mag;
    sat_t                ms;

    always_comb begin
      stg_nxt = stg_r[i-1];
      // One restoring division step: shift in a numerator bit, try the divisor.
      trial   = {stg_r[i-1].rem, stg_r[i-1].nq[NUM_W-1]};
      if (trial >= {1'b0, stg_r[i-1].mb}) begin
        stg_nxt.rem = WORD_WIDTH'(trial - {1'b0, stg_r[i-1].mb});
        stg_nxt.nq  = {stg_r[i-1].nq[NUM_W-2:0], 1'b1};
      end else begin
        stg_nxt.rem = trial[WORD_WIDTH-1:0];
        stg_nxt.nq  = {stg_r[i-1].nq[NUM_W-2:0], 1'b0};
      end
      rounded = {1'b0, prod_r} + (2*WORD_WIDTH+1)'(1 << (FRAC_BITS-1));
      mul_mag = 64'(rounded >> FRAC_BITS);
      ms      = sat_mag(stg_r[i-1].neg, mul_mag);
      // The product register belongs to stage zero, so multiplies finish here.
      if (i == 1 && stg_r[i-1].kind == KIND_MUL) begin
        stg_nxt.kind = KIND_DONE;
        stg_nxt.res  = ms.val;
        stg_nxt.st   = ms.ovf ? ST_OVF : ST_OK;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[i].vld <= 1'b0;
      end else if (en) begin
        stg_r[i].vld <= stg_r[i-1].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i].kind <= stg_nxt.kind;
        stg_r[i].res  <= stg_nxt.res;
        stg_r[i].cmp  <= stg_nxt.cmp;
        stg_r[i].st   <= stg_nxt.st;
        stg_r[i].neg  <= stg_nxt.neg;
        stg_r[i].mb   <= stg_nxt.mb;
        stg_r[i].rem  <= stg_nxt.rem;
        stg_r[i].nq   <= stg_nxt.nq;
      end
    end
  end

  stage_t              last;
  logic                rnd_up;
  logic [NUM_W:0]      quo;
  sat_t                ds;
  logic [WORD_WIDTH-1:0] res_nxt;
  logic [1:0]          st_nxt;

  always_comb begin
    last    = stg_r[DIV_STEPS];
    // Round half away from zero: bump when twice the remainder reaches the divisor.
    rnd_up  = ({last.rem, 1'b0} >= {1'b0, last.mb});
    quo     = {1'b0, last.nq} + (NUM_W+1)'(rnd_up);
    ds      = sat_mag(last.neg, 64'(quo));
    res_nxt = last.res;
    st_nxt  = last.st;
    if (last.kind == KIND_DIV) begin
      res_nxt = ds.val;
      st_nxt  = ds.ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
      out_cmp_r <= last.cmp;
      out_st_r  <= st_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.compare_true = out_cmp_r;
  assign out_ch.status       = out_st_r;

  `FXA_ASSERT_SAME(a_div_has_divisor, stg_r[0].vld && stg_r[0].kind == KIND_DIV, stg_r[0].mb != '0)
  `FXA_ASSERT_SAME(a_mul_done_early, stg_r[1].vld, stg_r[1].kind != KIND_MUL)
  `FXA_ASSERT_SAME(a_cmp_clean, out_vld_r && out_cmp_r, out_res_r == '0 && out_st_r == ST_OK)
  `FXA_ASSERT_SAME(a_ovf_at_limit, out_vld_r && out_st_r == ST_OVF, out_res_r == WORD_MAX || out_res_r == WORD_MIN)
  `FXA_ASSERT_NEXT(a_stall_holds_last, !en && last.vld, stg_r[DIV_STEPS].vld)
endmodule
`default_nettype wire

// ===== design/fixed_point_q24_8_alu_unit.sv =====
// Top level of the Q24.8 fixed-point ALU.
//  channel  | direction | payload
//  in_ch    | sink      | op, operand_a, operand_b
//  out_ch   | source    | result_value, compare_true, status
// Accepts one word per cycle unless the queue is full; delivers one result per cycle
// in order while out_ch is ready. Every op passes the 40-stage bit-per-stage divider.
// Reset is synchronous and active low; it clears the queue and all valid bits.
// A stalled output freezes the back-end pipeline; the 4-entry queue fills meanwhile.
`default_nettype none
module fixed_point_q24_8_alu_unit import fxa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  fxa_in_if.sink    in_ch,
  fxa_out_if.source out_ch
);
  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_out;

  fxa_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  fxa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  fxa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_out),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire
